[hw/rtl/lfmmc_pkg.sv]
// Shared types, register codes, reset values and helpers for the line follower mode control.
package lfmmc_pkg;

    // Operating mode
    typedef enum logic [1:0] {
        MODE_FOLLOW = 2'd0,
        MODE_SLOW   = 2'd1,
        MODE_STOP   = 2'd2
    } t_mode;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_WHITE_THRESHOLD = 3'd0,
        CFG_CROSSOVER_COUNT = 3'd1,
        CFG_CONFIRM_TICKS   = 3'd2,
        CFG_LOCKOUT_TICKS   = 3'd3,
        CFG_STOP_TICKS      = 3'd4,
        CFG_BIAS_TICKS      = 3'd5,
        CFG_BIAS_MAGNITUDE  = 3'd6
    } t_cfg_idx;

    // Colour classes
    localparam logic [1:0] COLOUR_RED   = 2'd1;
    localparam logic [1:0] COLOUR_GREEN = 2'd2;

    localparam int CFG_DATA_W = 10;

    // Register reset values
    localparam logic [9:0] RST_WHITE_THRESHOLD = 10'd512;
    localparam logic [2:0] RST_CROSSOVER_COUNT = 3'd3;
    localparam logic [2:0] RST_CONFIRM_TICKS   = 3'd3;
    localparam logic [7:0] RST_LOCKOUT_TICKS   = 8'd20;
    localparam logic [9:0] RST_STOP_TICKS      = 10'd200;
    localparam logic [7:0] RST_BIAS_TICKS      = 8'd60;
    localparam logic [7:0] RST_BIAS_MAGNITUDE  = 8'd25;

    // Debounce counter step: clears on a miss, counts up to the confirm limit on a hit
    function automatic logic [2:0] debounce(input logic [2:0] cnt, input logic hit,
                                            input logic [2:0] limit);
        logic [2:0] res;
        if (!hit) begin
            res = 3'd0;
        end else if (cnt < limit) begin
            res = cnt + 3'd1;
        end else begin
            res = cnt;
        end
        return res;
    endfunction

endpackage

[hw/rtl/line_follower_marker_mode_control.sv]
// Line follower marker detection, mode control, steering bias and LED state.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+-------------------------------------
//  in      | input     | i_in_valid / o_in_stall    | four sensors, colour, steer, bumps
//  out     | output    | o_out_valid / i_out_stall  | motor command, flags, LEDs, laps, mode
//  cfg     | input     | i_cfg_we                   | i_cfg_index, i_cfg_data
//
// One item per cycle while the output is not stalled; each item passes the input register,
// then one pass of threshold/debounce/mode logic into the state and result registers.
// Reset (i_rst_n low, synchronous) clears all control state and loads register defaults.
// The result register and the input register each hold one item, so the input side can take
// one more item while a result waits; a stall on the output backs up into o_in_stall.
module line_follower_marker_mode_control (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [9:0]  i_sensor_left,
    input  logic [9:0]  i_sensor_left_mid,
    input  logic [9:0]  i_sensor_right_mid,
    input  logic [9:0]  i_sensor_right,
    input  logic [1:0]  i_colour_class,
    input  logic signed [15:0] i_steer_value,
    input  logic        i_bump_left,
    input  logic        i_bump_right,
    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_motor_action,
    output logic signed [15:0] o_motor_drive,
    output logic        o_slow_zone_flag,
    output logic        o_led_red_on,
    output logic        o_led_green_on,
    output logic        o_led_blue_on,
    output logic [7:0]  o_laps_done,
    output logic [1:0]  o_mode_now,
    // configuration port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [lfmmc_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    // Configuration registers
    logic [9:0] r_white_threshold;
    logic [2:0] r_crossover_count;
    logic [2:0] r_confirm_ticks;
    logic [7:0] r_lockout_ticks;
    logic [9:0] r_stop_ticks;
    logic [7:0] r_bias_ticks;
    logic [7:0] r_bias_magnitude;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_white_threshold <= lfmmc_pkg::RST_WHITE_THRESHOLD;
            r_crossover_count <= lfmmc_pkg::RST_CROSSOVER_COUNT;
            r_confirm_ticks   <= lfmmc_pkg::RST_CONFIRM_TICKS;
            r_lockout_ticks   <= lfmmc_pkg::RST_LOCKOUT_TICKS;
            r_stop_ticks      <= lfmmc_pkg::RST_STOP_TICKS;
            r_bias_ticks      <= lfmmc_pkg::RST_BIAS_TICKS;
            r_bias_magnitude  <= lfmmc_pkg::RST_BIAS_MAGNITUDE;
        end else if (i_cfg_we) begin
            case (lfmmc_pkg::t_cfg_idx'(i_cfg_index))
                lfmmc_pkg::CFG_WHITE_THRESHOLD: r_white_threshold <= i_cfg_data[9:0];
                lfmmc_pkg::CFG_CROSSOVER_COUNT: r_crossover_count <= i_cfg_data[2:0];
                lfmmc_pkg::CFG_CONFIRM_TICKS:   r_confirm_ticks   <= i_cfg_data[2:0];
                lfmmc_pkg::CFG_LOCKOUT_TICKS:   r_lockout_ticks   <= i_cfg_data[7:0];
                lfmmc_pkg::CFG_STOP_TICKS:      r_stop_ticks      <= i_cfg_data[9:0];
                lfmmc_pkg::CFG_BIAS_TICKS:      r_bias_ticks      <= i_cfg_data[7:0];
                lfmmc_pkg::CFG_BIAS_MAGNITUDE:  r_bias_magnitude  <= i_cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Handshake and input register
    logic        r_in_valid;
    logic        r_out_valid;
    logic        w_fire;
    logic        w_in_accept;
    logic [9:0]  r_sensor_left;
    logic [9:0]  r_sensor_left_mid;
    logic [9:0]  r_sensor_right_mid;
    logic [9:0]  r_sensor_right;
    logic [1:0]  r_colour;
    logic signed [15:0] r_steer;
    logic        r_bump;

    assign w_fire      = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !w_fire;
    assign w_in_accept = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_in_accept) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_sensor_left      <= i_sensor_left;
            r_sensor_left_mid  <= i_sensor_left_mid;
            r_sensor_right_mid <= i_sensor_right_mid;
            r_sensor_right     <= i_sensor_right;
            r_colour           <= i_colour_class;
            r_steer            <= i_steer_value;
            r_bump             <= i_bump_left | i_bump_right;
        end
    end

    // Control state
    lfmmc_pkg::t_mode r_mode, n_mode;
    logic [9:0] r_stop_count, n_stop_count;
    logic [7:0] r_lap_total, n_lap_total;
    logic [7:0] r_bias_count, n_bias_count;
    logic [7:0] r_lockout_count, n_lockout_count;
    logic       r_armed, n_armed;
    logic [2:0] r_finish_count, n_finish_count;
    logic [2:0] r_red_count, n_red_count;
    logic [2:0] r_green_count, n_green_count;
    logic [2:0] r_left_count, n_left_count;
    logic       r_left_seen, n_left_seen;
    logic       r_on_straight, n_on_straight;
    logic       r_led_red, n_led_red;
    logic       r_led_green, n_led_green;
    logic       r_led_blue, n_led_blue;
    logic       r_slow_flag, n_slow_flag;
    logic       r_action, n_action;
    logic signed [15:0] r_drive, n_drive;

    // Thresholding, crossover lockout and corner marker
    logic       w_l, w_lm, w_rm, w_r;
    logic [2:0] w_white_cnt;
    logic       w_cx;
    logic [7:0] w_lockout;
    logic       w_blocked;
    logic [2:0] w_left_cnt;
    logic       w_left_seen;
    logic       w_straight;

    always_comb begin
        w_l  = r_sensor_left      > r_white_threshold;
        w_lm = r_sensor_left_mid  > r_white_threshold;
        w_rm = r_sensor_right_mid > r_white_threshold;
        w_r  = r_sensor_right     > r_white_threshold;
        w_white_cnt = {2'b00, w_l} + {2'b00, w_lm} + {2'b00, w_rm} + {2'b00, w_r};
        w_cx = w_white_cnt >= r_crossover_count;
        if (w_cx) begin
            w_lockout = r_lockout_ticks;
        end else if (r_lockout_count != 8'd0) begin
            w_lockout = r_lockout_count - 8'd1;
        end else begin
            w_lockout = 8'd0;
        end
        w_blocked   = w_cx || (w_lockout != 8'd0);
        w_left_cnt  = lfmmc_pkg::debounce(r_left_count, !w_blocked && w_l && !w_r,
                                          r_confirm_ticks);
        w_left_seen = w_left_cnt >= r_confirm_ticks;
        w_straight  = r_on_straight ^ (w_left_seen && !r_left_seen);
    end

    // Marker and timer decisions
    logic [9:0] w_stop_inc;
    logic       w_stop_done;
    logic [2:0] w_green_cnt, w_red_cnt, w_finish_cnt;
    logic       w_green_ok, w_red_ok, w_finish;

    always_comb begin
        w_stop_inc   = r_stop_count + 10'd1;
        w_stop_done  = w_stop_inc >= r_stop_ticks;
        w_green_cnt  = lfmmc_pkg::debounce(r_green_count, r_colour == lfmmc_pkg::COLOUR_GREEN,
                                           r_confirm_ticks);
        w_green_ok   = w_green_cnt >= r_confirm_ticks;
        w_red_cnt    = lfmmc_pkg::debounce(r_red_count, r_colour == lfmmc_pkg::COLOUR_RED,
                                           r_confirm_ticks);
        w_red_ok     = w_red_cnt >= r_confirm_ticks;
        w_finish_cnt = lfmmc_pkg::debounce(r_finish_count, !w_blocked && w_r && !w_l,
                                           r_confirm_ticks);
        w_finish     = r_armed && (w_finish_cnt >= r_confirm_ticks);
    end

    // Biased steering, saturated to 16 bits
    logic signed [16:0] w_bias;
    logic signed [16:0] w_sum;
    logic signed [15:0] w_biased;

    always_comb begin
        w_bias = r_lap_total[0] ? $signed({9'd0, r_bias_magnitude})
                                : -$signed({9'd0, r_bias_magnitude});
        w_sum  = {r_steer[15], r_steer} + w_bias;
        if (w_sum[16] != w_sum[15]) begin
            w_biased = w_sum[16] ? 16'sh8000 : 16'sh7FFF;
        end else begin
            w_biased = w_sum[15:0];
        end
    end

    // Next mode
    always_comb begin
        case (r_mode)
            lfmmc_pkg::MODE_STOP: begin
                n_mode = w_stop_done ? lfmmc_pkg::MODE_FOLLOW : lfmmc_pkg::MODE_STOP;
            end
            lfmmc_pkg::MODE_SLOW: begin
                n_mode = w_green_ok ? lfmmc_pkg::MODE_FOLLOW : lfmmc_pkg::MODE_SLOW;
            end
            default: begin
                if (w_finish) begin
                    n_mode = lfmmc_pkg::MODE_STOP;
                end else if (w_red_ok) begin
                    n_mode = lfmmc_pkg::MODE_SLOW;
                end else begin
                    n_mode = lfmmc_pkg::MODE_FOLLOW;
                end
            end
        endcase
    end

    // Counters, flags, LEDs and motor command
    always_comb begin
        n_stop_count    = r_stop_count;
        n_lap_total     = r_lap_total;
        n_bias_count    = r_bias_count;
        n_lockout_count = r_lockout_count;
        n_armed         = r_armed;
        n_finish_count  = r_finish_count;
        n_red_count     = r_red_count;
        n_green_count   = r_green_count;
        n_left_count    = r_left_count;
        n_left_seen     = r_left_seen;
        n_on_straight   = r_on_straight;
        n_led_red       = r_led_red;
        n_led_green     = r_led_green;
        n_led_blue      = r_led_blue;
        n_slow_flag     = r_slow_flag;
        n_action        = 1'b1;
        n_drive         = r_steer;
        case (r_mode)
            lfmmc_pkg::MODE_STOP: begin
                n_action     = 1'b0;
                n_drive      = 16'sd0;
                n_led_red    = !w_stop_done;
                n_led_green  = 1'b0;
                n_led_blue   = 1'b0;
                n_stop_count = w_stop_done ? 10'd0 : w_stop_inc;
                n_armed      = r_armed && !w_stop_done;
            end
            lfmmc_pkg::MODE_SLOW: begin
                n_lockout_count = w_lockout;
                n_left_count    = w_left_cnt;
                n_left_seen     = w_left_seen;
                n_on_straight   = w_straight;
                n_led_green     = w_straight;
                n_led_blue      = r_bump;
                n_slow_flag     = !w_green_ok;
                if (r_bias_count != 8'd0) begin
                    n_bias_count = r_bias_count - 8'd1;
                    n_drive      = w_biased;
                end
                // green confirmed: leave slow zone and drop any remaining bias
                if (w_green_ok) begin
                    n_green_count = 3'd0;
                    n_bias_count  = 8'd0;
                end else begin
                    n_green_count = w_green_cnt;
                end
            end
            default: begin
                n_lockout_count = w_lockout;
                n_left_count    = w_left_cnt;
                n_left_seen     = w_left_seen;
                n_on_straight   = w_straight;
                n_led_green     = w_straight;
                n_led_blue      = 1'b0;
                n_slow_flag     = 1'b0;
                // finish marker only counts once armed by a dark right sensor
                if (!r_armed) begin
                    n_armed = !w_r;
                end else begin
                    n_finish_count = w_finish_cnt;
                end
                if (w_finish) begin
                    n_lap_total    = r_lap_total + 8'd1;
                    n_finish_count = 3'd0;
                    n_stop_count   = 10'd0;
                end else if (w_red_ok) begin
                    n_red_count  = 3'd0;
                    n_bias_count = r_bias_ticks;
                end else begin
                    n_red_count = w_red_cnt;
                end
            end
        endcase
    end

    // State and result registers, updated once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= lfmmc_pkg::MODE_FOLLOW;
            r_stop_count    <= 10'd0;
            r_lap_total     <= 8'd0;
            r_bias_count    <= 8'd0;
            r_lockout_count <= 8'd0;
            r_armed         <= 1'b0;
            r_finish_count  <= 3'd0;
            r_red_count     <= 3'd0;
            r_green_count   <= 3'd0;
            r_left_count    <= 3'd0;
            r_left_seen     <= 1'b0;
            r_on_straight   <= 1'b1;
            r_led_red       <= 1'b0;
            r_led_green     <= 1'b0;
            r_led_blue      <= 1'b0;
            r_slow_flag     <= 1'b0;
        end else if (w_fire) begin
            r_mode          <= n_mode;
            r_stop_count    <= n_stop_count;
            r_lap_total     <= n_lap_total;
            r_bias_count    <= n_bias_count;
            r_lockout_count <= n_lockout_count;
            r_armed         <= n_armed;
            r_finish_count  <= n_finish_count;
            r_red_count     <= n_red_count;
            r_green_count   <= n_green_count;
            r_left_count    <= n_left_count;
            r_left_seen     <= n_left_seen;
            r_on_straight   <= n_on_straight;
            r_led_red       <= n_led_red;
            r_led_green     <= n_led_green;
            r_led_blue      <= n_led_blue;
            r_slow_flag     <= n_slow_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_action <= n_action;
            r_drive  <= n_drive;
        end
    end

    // Result fields: the state after the step is held until the item leaves
    assign o_out_valid      = r_out_valid;
    assign o_motor_action   = r_action;
    assign o_motor_drive    = r_drive;
    assign o_slow_zone_flag = r_slow_flag;
    assign o_led_red_on     = r_led_red;
    assign o_led_green_on   = r_led_green;
    assign o_led_blue_on    = r_led_blue;
    assign o_laps_done      = r_lap_total;
    assign o_mode_now       = r_mode;

endmodule
